// ===== design/mrs_pkg.sv =====
// Shared types, constants and saturation helpers for the regression sampler.
package mrs_pkg;

  localparam int MRS_MAX_ROWS = 256;
  localparam int MRS_MAX_COEFS = 8;
  localparam int FRAC_BITS = 16;

  localparam int LP_W = 48;
  localparam int MUL_W = 34;
  localparam int PROD_W = 2 * MUL_W;
  localparam int DIV_W = 64;
  localparam int SQ_STEPS = FRAC_BITS;
  localparam int TAYLOR_TERMS = 13;
  localparam int EXP_CUTOFF = 12;

  localparam logic [1:0] FUNC_LOAD_X = 2'd0;
  localparam logic [1:0] FUNC_LOAD_Y = 2'd1;
  localparam logic [1:0] FUNC_LOAD_NOISE = 2'd2;
  localparam logic [1:0] FUNC_STEP = 2'd3;

  localparam logic [1:0] REG_ROW_COUNT = 2'd0;
  localparam logic [1:0] REG_COEF_COUNT = 2'd1;
  localparam logic [1:0] REG_STEP_SIZE = 2'd2;

  localparam logic [8:0] ROW_COUNT_RST = 9'd1;
  localparam logic [3:0] COEF_COUNT_RST = 4'd1;
  localparam logic [30:0] STEP_SIZE_RST = 31'd442;

  localparam logic [31:0] LN2_Q32 = 32'd2977044472;
  localparam logic [31:0] EINV_Q32 = 32'd1580030169;
  localparam logic [13:0] HALF_MILLI_Q24 = 14'd8389;

  localparam logic signed [63:0] LP_MAX_W = 64'sd140737488355327;
  localparam logic signed [63:0] LP_MIN_W = -LP_MAX_W - 64'sd1;
  localparam logic signed [63:0] W32_MAX_W = 64'sd2147483647;
  localparam logic signed [63:0] W32_MIN_W = -W32_MAX_W - 64'sd1;

  typedef enum logic [5:0] {
    S_IDLE, S_SP_MUL, S_SP_ADD, S_PROP_MUL, S_PROP_ADD, S_EVAL,
    L_INIT, L_B2_MUL, L_B2_ACC, L_ROW, L_MU_MUL, L_MU_ACC,
    L_RES, L_RES_MUL, L_RES_ACC, L_NORM, L_SQ_MUL, L_SQ,
    L_LG_MUL, L_LG, L_A_MUL, L_A, L_BT_HI, L_BT_LO, L_BT_FIN,
    L_C_DIV, L_C_WAIT, L_D_DIV, L_D_WAIT, L_DONE,
    S_DIFF, E_MUL, E_DIV, E_WAIT, E_ACC, E_CLAMP, E_Q, E_QACC, E_CMP,
    S_UPDATE, S_EMIT
  } state_t;

  function automatic logic signed [LP_W-1:0] clamp48(input logic signed [63:0] v);
    if (v > LP_MAX_W) begin
      return LP_W'(LP_MAX_W);
    end else if (v < LP_MIN_W) begin
      return LP_W'(LP_MIN_W);
    end
    return LP_W'(v);
  endfunction

  function automatic logic ovf48(input logic signed [63:0] v);
    return (v > LP_MAX_W) || (v < LP_MIN_W);
  endfunction

  function automatic logic signed [31:0] clamp32(input logic signed [63:0] v);
    if (v > W32_MAX_W) begin
      return 32'(W32_MAX_W);
    end else if (v < W32_MIN_W) begin
      return 32'(W32_MIN_W);
    end
    return 32'(v);
  endfunction

  function automatic logic ovf32(input logic signed [63:0] v);
    return (v > W32_MAX_W) || (v < W32_MIN_W);
  endfunction

endpackage

// ===== design/metropolis_regression_sampler_top.sv =====
// Random-walk Metropolis sampler for Bayesian linear regression, Q16.16 fixed point.
// Loads (design element, response, coefficient draw) leave the block idle, so another
// request can be taken straight after one. A step runs on one shared 34x34 multiplier
// with a registered product and a one-bit-per-cycle 64-bit divider under a sequencer,
// so its length follows from the loop counts: with n rows and p coefficients a log
// posterior evaluation is mostly the row-by-coefficient multiply-accumulate and two
// divides. A step computes the proposal, runs one evaluation (two when a load or a row
// or coefficient count write made the stored posterior stale, or after reset), then
// the exponential when the proposal is worse (thirteen series terms, each a divide),
// takes the proposal if accepted, and hands out the coefficients and then the variance,
// holding while the output is stalled. A step whose variance proposal is not positive
// skips straight to the results. The block takes no request while a step is running;
// a result still held on the output does not block the next request.
module metropolis_regression_sampler_top
  import mrs_pkg::*;
#(
  parameter int MAX_ROWS = MRS_MAX_ROWS,
  parameter int MAX_COEFS = MRS_MAX_COEFS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               req_valid,
  output logic               req_stall,
  input  logic [1:0]         func,
  input  logic [7:0]         row_index,
  input  logic [2:0]         col_index,
  input  logic signed [31:0] data_value,
  input  logic [15:0]        uniform_draw,
  output logic               rsp_valid,
  input  logic               rsp_stall,
  output logic [3:0]         param_index,
  output logic signed [31:0] param_value,
  output logic               accepted,
  output logic               saturated,
  output logic               last
);

  localparam int RW = $clog2(MAX_ROWS + 1);
  localparam int RIW = $clog2(MAX_ROWS);
  localparam int COLW = $clog2(MAX_COEFS + 1);
  localparam int CIW = (MAX_COEFS > 1) ? $clog2(MAX_COEFS) : 1;
  localparam int DSG_DEPTH = MAX_ROWS * MAX_COEFS;
  localparam int DAW = (DSG_DEPTH > 1) ? $clog2(DSG_DEPTH) : 1;

  state_t state, state_next;

  logic [8:0]  row_count;
  logic [3:0]  coef_count;
  logic [30:0] step_size;
  logic        cfg_wr;

  logic [RW-1:0]   n_use, row, rd_row;
  logic [COLW-1:0] p_use, col, rd_col;
  logic [CIW-1:0]  ci;
  logic [DAW-1:0]  rd_addr, ld_addr;
  logic [13:0]     n3;

  logic signed [31:0] coef  [MAX_COEFS];
  logic signed [31:0] prop  [MAX_COEFS];
  logic signed [31:0] noise [MAX_COEFS];
  logic signed [31:0] dsg_mem [DSG_DEPTH];
  logic signed [31:0] resp_mem [MAX_ROWS];
  logic signed [31:0] dsg_q, resp_q;

  logic signed [31:0] nv, sp, dv, r_val, b_cur, s_cur;
  logic [15:0]        u;
  logic signed [LP_W-1:0] clp, nlp, sumb2, ssr, mu, a_t, bt_t, c_t, d_t;
  logic lpv, lp_clr, eval_prop, acc, sat;

  logic [30:0]          m;
  logic [4:0]           k, iter;
  logic [FRAC_BITS-1:0] frac, ef;
  logic [3:0]           eq;
  logic [32:0]          term, er;
  logic signed [35:0]   esum;
  logic signed [FRAC_BITS+5:0] lg_val;
  logic [31:0]          sq_hi;

  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0] mul_p;
  logic signed [63:0] prod_f, sp_sum, prop_sum, b2_sum, mu_sum, res_diff, ssr_sum;
  logic signed [63:0] lp_sum, diff, negd;

  logic              div_start, div_busy, div_ge;
  logic [DIV_W-1:0]  div_dividend, div_q;
  logic [30:0]       div_divisor, div_d, div_rem;
  logic [31:0]       div_sh, div_sub;
  logic [5:0]        div_cnt;

  logic req_acc, emit_go, ld_x, ld_y;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign req_stall = (state != S_IDLE);
  assign req_acc = req_valid && !req_stall;
  assign emit_go = !rsp_valid || !rsp_stall;

  assign n_use = (int'(row_count) > MAX_ROWS) ? RW'(MAX_ROWS) : RW'(row_count);
  assign p_use = (int'(coef_count) > MAX_COEFS) ? COLW'(MAX_COEFS) : COLW'(coef_count);
  assign n3 = 14'(n_use) + 14'd3;
  assign ci = col[CIW-1:0];
  assign b_cur = eval_prop ? prop[ci] : coef[ci];
  assign s_cur = eval_prop ? sp : nv;

  assign ld_x = req_acc && (func == FUNC_LOAD_X) && (int'(row_index) < MAX_ROWS)
                && (int'(col_index) < MAX_COEFS);
  assign ld_y = req_acc && (func == FUNC_LOAD_Y) && (int'(row_index) < MAX_ROWS);
  assign lp_clr = ld_x || ld_y || (cfg_wr && (paddr[3:2] == REG_ROW_COUNT
                  || paddr[3:2] == REG_COEF_COUNT));
  assign ld_addr = DAW'(int'(row_index) * MAX_COEFS + int'(col_index));
  assign rd_row = row;
  assign rd_col = (state == L_ROW) ? '0 : (state == L_MU_ACC) ? col + 1'b1 : col;
  assign rd_addr = DAW'(int'(rd_row) * MAX_COEFS + int'(rd_col));

  assign prod_f = 64'(mul_p >>> FRAC_BITS);
  assign sp_sum = 64'(nv) + prod_f;
  assign prop_sum = 64'(coef[ci]) + prod_f;
  assign b2_sum = 64'(sumb2) + prod_f;
  assign mu_sum = 64'(mu) + prod_f;
  assign res_diff = 64'(resp_q) - 64'(mu);
  assign ssr_sum = 64'(ssr) + prod_f;
  assign lp_sum = -64'(a_t) - 64'(bt_t) - 64'(c_t) - 64'(d_t);
  assign diff = 64'(nlp) - 64'(clp);
  assign negd = -diff;
  assign sq_hi = mul_p[61:30];
  assign lg_val = {6'({1'b0, k}) - 6'd16, frac};

  always_comb begin
    case (paddr[3:2])
      REG_ROW_COUNT:  prdata = {23'd0, row_count};
      REG_COEF_COUNT: prdata = {28'd0, coef_count};
      REG_STEP_SIZE:  prdata = {1'b0, step_size};
      default:        prdata = '0;
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:     if (req_acc && func == FUNC_STEP) state_next = S_SP_MUL;
      S_SP_MUL:   state_next = S_SP_ADD;
      S_SP_ADD: begin
        if (sp_sum <= 64'sd0) state_next = S_EMIT;
        else if (p_use == '0) state_next = S_EVAL;
        else state_next = S_PROP_MUL;
      end
      S_PROP_MUL: state_next = S_PROP_ADD;
      S_PROP_ADD: state_next = (col + 1'b1 == p_use) ? S_EVAL : S_PROP_MUL;
      S_EVAL:     state_next = L_INIT;
      L_INIT:     state_next = (p_use == '0) ? L_ROW : L_B2_MUL;
      L_B2_MUL:   state_next = L_B2_ACC;
      L_B2_ACC:   state_next = (col + 1'b1 == p_use) ? L_ROW : L_B2_MUL;
      L_ROW: begin
        if (row == n_use) state_next = L_NORM;
        else if (p_use == '0) state_next = L_RES;
        else state_next = L_MU_MUL;
      end
      L_MU_MUL:   state_next = L_MU_ACC;
      L_MU_ACC:   state_next = (col + 1'b1 == p_use) ? L_RES : L_MU_MUL;
      L_RES:      state_next = L_RES_MUL;
      L_RES_MUL:  state_next = L_RES_ACC;
      L_RES_ACC:  state_next = L_ROW;
      L_NORM:     if (m[30] || k == '0) state_next = L_SQ_MUL;
      L_SQ_MUL:   state_next = L_SQ;
      L_SQ:       state_next = (iter == 5'(SQ_STEPS - 1)) ? L_LG_MUL : L_SQ_MUL;
      L_LG_MUL:   state_next = L_LG;
      L_LG:       state_next = L_A_MUL;
      L_A_MUL:    state_next = L_A;
      L_A:        state_next = L_BT_HI;
      L_BT_HI:    state_next = L_BT_LO;
      L_BT_LO:    state_next = L_BT_FIN;
      L_BT_FIN:   state_next = L_C_DIV;
      L_C_DIV:    state_next = L_C_WAIT;
      L_C_WAIT:   if (!div_busy) state_next = L_D_DIV;
      L_D_DIV:    state_next = L_D_WAIT;
      L_D_WAIT:   if (!div_busy) state_next = L_DONE;
      L_DONE:     state_next = eval_prop ? S_DIFF : L_INIT;
      S_DIFF: begin
        if (diff >= 64'sd0) state_next = S_UPDATE;
        else if (negd[63:FRAC_BITS] >= (64 - FRAC_BITS)'(EXP_CUTOFF)) state_next = S_EMIT;
        else state_next = E_MUL;
      end
      E_MUL:      state_next = E_DIV;
      E_DIV:      state_next = E_WAIT;
      E_WAIT:     if (!div_busy) state_next = E_ACC;
      E_ACC:      state_next = (iter == 5'(TAYLOR_TERMS)) ? E_CLAMP : E_MUL;
      E_CLAMP:    state_next = E_Q;
      E_Q:        state_next = (eq == '0) ? E_CMP : E_QACC;
      E_QACC:     state_next = E_Q;
      E_CMP:      state_next = ({1'b0, u} < er[32:16]) ? S_UPDATE : S_EMIT;
      S_UPDATE:   state_next = S_EMIT;
      S_EMIT:     if (emit_go && col == p_use) state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  // shared multiplier and divider operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    div_start = 1'b0;
    div_dividend = '0;
    div_divisor = '0;
    case (state)
      S_SP_MUL: begin
        mul_a = {3'b0, step_size};
        mul_b = MUL_W'(dv);
      end
      S_PROP_MUL: begin
        mul_a = {3'b0, step_size};
        mul_b = MUL_W'(noise[ci]);
      end
      L_B2_MUL: begin
        mul_a = MUL_W'(b_cur);
        mul_b = MUL_W'(b_cur);
      end
      L_MU_MUL: begin
        mul_a = MUL_W'(dsg_q);
        mul_b = MUL_W'(b_cur);
      end
      L_RES_MUL: begin
        mul_a = MUL_W'(r_val);
        mul_b = MUL_W'(r_val);
      end
      L_SQ_MUL: begin
        mul_a = {3'b0, m};
        mul_b = {3'b0, m};
      end
      L_LG_MUL: begin
        mul_a = MUL_W'(lg_val);
        mul_b = {2'b0, LN2_Q32};
      end
      L_A_MUL: begin
        mul_a = {20'b0, n3};
        mul_b = MUL_W'(a_t);
      end
      L_BT_HI: begin
        mul_a = {10'b0, sumb2[47:24]};
        mul_b = {20'b0, HALF_MILLI_Q24};
      end
      L_BT_LO: begin
        mul_a = {10'b0, sumb2[23:0]};
        mul_b = {20'b0, HALF_MILLI_Q24};
      end
      L_C_DIV: begin
        div_start = 1'b1;
        div_dividend = DIV_W'(3) << (2 * FRAC_BITS - 1);
        div_divisor = s_cur[30:0];
      end
      L_D_DIV: begin
        div_start = 1'b1;
        div_dividend = DIV_W'(ssr) << (FRAC_BITS - 1);
        div_divisor = s_cur[30:0];
      end
      E_MUL: begin
        mul_a = {1'b0, term};
        mul_b = {2'b0, ef, {FRAC_BITS{1'b0}}};
      end
      E_DIV: begin
        div_start = 1'b1;
        div_dividend = DIV_W'(mul_p[63:32]);
        div_divisor = 31'(iter);
      end
      E_Q: begin
        mul_a = {1'b0, er};
        mul_b = {2'b0, EINV_Q32};
      end
      default: begin
        mul_a = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    mul_p <= mul_a * mul_b;
  end

  assign div_sh = {div_rem, div_q[DIV_W-1]};
  assign div_ge = div_sh >= {1'b0, div_d};
  assign div_sub = div_sh - {1'b0, div_d};

  always_ff @(posedge clk) begin
    if (rst) begin
      div_busy <= 1'b0;
    end else if (div_start) begin
      div_busy <= 1'b1;
      div_q <= div_dividend;
      div_rem <= '0;
      div_d <= div_divisor;
      div_cnt <= '0;
    end else if (div_busy) begin
      div_rem <= div_ge ? div_sub[30:0] : div_sh[30:0];
      div_q <= {div_q[DIV_W-2:0], div_ge};
      div_cnt <= div_cnt + 1'b1;
      if (div_cnt == 6'(DIV_W - 1)) div_busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ld_x) dsg_mem[ld_addr] <= data_value;
    if (ld_y) resp_mem[RIW'(row_index)] <= data_value;
    dsg_q <= dsg_mem[rd_addr];
    resp_q <= resp_mem[rd_row[RIW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      row_count <= ROW_COUNT_RST;
      coef_count <= COEF_COUNT_RST;
      step_size <= STEP_SIZE_RST;
      lpv <= 1'b0;
      clp <= '0;
      nv <= 32'sd1 <<< FRAC_BITS;
      rsp_valid <= 1'b0;
      for (int j = 0; j < MAX_COEFS; j++) begin
        coef[j] <= '0;
        noise[j] <= '0;
      end
    end else begin
      state <= state_next;
      if (state == S_EMIT && emit_go) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      if (lp_clr) begin
        lpv <= 1'b0;
      end else if (state == L_DONE && !eval_prop) begin
        lpv <= 1'b1;
      end
      if (cfg_wr) begin
        case (paddr[3:2])
          REG_ROW_COUNT:  row_count <= pwdata[8:0];
          REG_COEF_COUNT: coef_count <= pwdata[3:0];
          REG_STEP_SIZE:  step_size <= pwdata[30:0];
          default: step_size <= step_size;
        endcase
      end
      case (state)
        S_IDLE: begin
          if (req_acc && func == FUNC_LOAD_NOISE && int'(col_index) < MAX_COEFS) begin
            noise[CIW'(col_index)] <= data_value;
          end
          if (req_acc && func == FUNC_STEP) begin
            dv <= data_value;
            u <= uniform_draw;
            acc <= 1'b0;
            sat <= 1'b0;
          end
        end
        S_SP_ADD: begin
          sp <= clamp32(sp_sum);
          if (ovf32(sp_sum)) sat <= 1'b1;
        end
        S_PROP_ADD: begin
          prop[ci] <= clamp32(prop_sum);
          if (ovf32(prop_sum)) sat <= 1'b1;
          col <= col + 1'b1;
        end
        S_EVAL: eval_prop <= lpv;
        L_INIT: begin
          sumb2 <= '0;
          ssr <= '0;
          col <= '0;
          row <= '0;
        end
        L_B2_ACC: begin
          sumb2 <= clamp48(b2_sum);
          if (ovf48(b2_sum)) sat <= 1'b1;
          col <= col + 1'b1;
        end
        L_ROW: begin
          mu <= '0;
          col <= '0;
          m <= s_cur[30:0];
          k <= 5'd30;
        end
        L_MU_ACC: begin
          mu <= clamp48(mu_sum);
          if (ovf48(mu_sum)) sat <= 1'b1;
          col <= col + 1'b1;
        end
        L_RES: begin
          r_val <= clamp32(res_diff);
          if (ovf32(res_diff)) sat <= 1'b1;
        end
        L_RES_ACC: begin
          ssr <= clamp48(ssr_sum);
          if (ovf48(ssr_sum)) sat <= 1'b1;
          row <= row + 1'b1;
        end
        L_NORM: begin
          iter <= '0;
          if (!m[30] && k != '0) begin
            m <= m << 1;
            k <= k - 1'b1;
          end
        end
        L_SQ: begin
          if (sq_hi[31]) begin
            m <= sq_hi[31:1];
            frac <= {frac[FRAC_BITS-2:0], 1'b1};
          end else begin
            m <= sq_hi[30:0];
            frac <= {frac[FRAC_BITS-2:0], 1'b0};
          end
          iter <= iter + 1'b1;
        end
        L_LG:     a_t <= LP_W'(mul_p >>> 32);
        L_A:      a_t <= LP_W'(mul_p >>> 1);
        L_BT_LO:  bt_t <= LP_W'(mul_p);
        L_BT_FIN: bt_t <= bt_t + LP_W'(mul_p >>> 24);
        L_C_WAIT: if (!div_busy) c_t <= LP_W'(div_q);
        L_D_WAIT: begin
          if (!div_busy) begin
            if (|div_q[DIV_W-1:LP_W-1]) begin
              d_t <= LP_W'(LP_MAX_W);
              sat <= 1'b1;
            end else begin
              d_t <= LP_W'(div_q);
            end
          end
        end
        L_DONE: begin
          if (ovf48(lp_sum)) sat <= 1'b1;
          if (!eval_prop) begin
            clp <= clamp48(lp_sum);
            eval_prop <= 1'b1;
          end else begin
            nlp <= clamp48(lp_sum);
          end
        end
        S_DIFF: begin
          if (diff >= 64'sd0) acc <= 1'b1;
          eq <= negd[FRAC_BITS+3:FRAC_BITS];
          ef <= negd[FRAC_BITS-1:0];
          term <= 33'd1 << 32;
          esum <= 36'sd1 <<< 32;
          iter <= 5'd1;
        end
        E_ACC: begin
          term <= 33'(div_q);
          if (iter[0]) esum <= esum - 36'(div_q);
          else esum <= esum + 36'(div_q);
          iter <= iter + 1'b1;
        end
        E_CLAMP: er <= (esum < 36'sd0) ? '0 : 33'(esum);
        E_QACC: begin
          er <= mul_p[64:32];
          eq <= eq - 1'b1;
        end
        E_CMP: acc <= {1'b0, u} < er[32:16];
        S_UPDATE: begin
          for (int j = 0; j < MAX_COEFS; j++) begin
            if (j < int'(p_use)) coef[j] <= prop[j];
          end
          nv <= sp;
          clp <= nlp;
        end
        S_EMIT: begin
          if (emit_go) begin
            param_index <= 4'(col);
            param_value <= (col < p_use) ? coef[ci] : nv;
            accepted <= acc;
            saturated <= sat;
            last <= (col == p_use);
            col <= col + 1'b1;
          end
        end
        default: ;
      endcase
      if ((state_next == S_EMIT && state != S_EMIT) || state == S_SP_ADD) col <= '0;
    end
  end

  a_var_positive: assert property (@(posedge clk) disable iff (rst) nv > 32'sd0)
    else $error("noise variance not positive");

  a_update_sp: assert property (@(posedge clk) disable iff (rst)
    state == S_UPDATE |-> sp > 32'sd0)
    else $error("update with non-positive proposal");

  a_div_idle: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_busy)
    else $error("divider started while busy");

  a_sums_nonneg: assert property (@(posedge clk) disable iff (rst)
    state == L_DONE |-> !sumb2[LP_W-1] && !ssr[LP_W-1])
    else $error("negative sum of squares");

  a_rsp_source: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state) == S_EMIT)
    else $error("result raised outside emit");

endmodule

// ===== test/mrs_checker.sv =====
// Scoreboard for the regression sampler: tracks register writes, predicts step results, compares.
`timescale 1ns / 100ps
module mrs_checker
  import mrs_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic               pready,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  input  logic               req_valid,
  input  logic               req_stall,
  input  logic [1:0]         func,
  input  logic [7:0]         row_index,
  input  logic [2:0]         col_index,
  input  logic signed [31:0] data_value,
  input  logic [15:0]        uniform_draw,
  input  logic               rsp_valid,
  input  logic               rsp_stall,
  input  logic [3:0]         param_index,
  input  logic signed [31:0] param_value,
  input  logic               accepted,
  input  logic               saturated,
  input  logic               last,
  output int                 fail_count,
  output int                 pending_count,
  output int                 request_count,
  output int                 step_count,
  output int                 accept_count,
  output int                 result_count
);

  typedef longint unsigned u64_t;
  typedef logic [MRS_MAX_COEFS-1:0][31:0] coef_vec_t;

  typedef struct packed {
    logic [3:0]         index;
    logic signed [31:0] value;
    logic               acc;
    logic               sat;
    logic               lst;
  } param_t;

  param_t             expected_params[$];
  logic signed [31:0] x_mem[MRS_MAX_ROWS*MRS_MAX_COEFS];
  logic signed [31:0] y_mem[MRS_MAX_ROWS];
  logic signed [31:0] noise_mem[MRS_MAX_COEFS];
  coef_vec_t          coef;
  coef_vec_t          prop;
  logic signed [31:0] variance;
  longint             cur_lp;
  bit                 lp_fresh;
  logic [8:0]         rows_cfg;
  logic [3:0]         coefs_cfg;
  logic [30:0]        step_cfg;
  bit                 sat_flag;

  function automatic longint clip(longint v, longint lo, longint hi);
    if (v < lo) begin
      sat_flag = 1'b1;
      return lo;
    end
    if (v > hi) begin
      sat_flag = 1'b1;
      return hi;
    end
    return v;
  endfunction

  function automatic int unsigned rows_used();
    return (rows_cfg > MRS_MAX_ROWS) ? MRS_MAX_ROWS : rows_cfg;
  endfunction

  function automatic int unsigned coefs_used();
    return (coefs_cfg > MRS_MAX_COEFS) ? MRS_MAX_COEFS : coefs_cfg;
  endfunction

  function automatic longint natural_log(u64_t s);
    int     k;
    int     i;
    u64_t   m;
    longint frac;
    longint lg;
    k = 30;
    frac = 0;
    if (s == 0) s = 1;
    while (k > 0 && s[k] == 1'b0) k--;
    m = s << (30 - k);
    for (i = 1; i <= FRAC_BITS; i++) begin
      m = (m * m) >> 30;
      if (m >= (u64_t'(1) << 31)) begin
        m = m >> 1;
        frac = frac | (longint'(1) << (FRAC_BITS - i));
      end
    end
    lg = longint'(k - FRAC_BITS) * (longint'(1) << FRAC_BITS) + frac;
    return (lg * longint'(LN2_Q32)) >>> 32;
  endfunction

  function automatic u64_t exp_neg(longint x);
    longint q;
    longint total;
    u64_t   f;
    u64_t   term;
    u64_t   r;
    int     k;
    q = x >>> FRAC_BITS;
    f = u64_t'(x & ((longint'(1) << FRAC_BITS) - 1)) << (32 - FRAC_BITS);
    term = u64_t'(1) << 32;
    total = longint'(1) << 32;
    if (q >= EXP_CUTOFF) return 0;
    for (k = 1; k <= TAYLOR_TERMS; k++) begin
      term = ((term * f) >> 32) / u64_t'(k);
      if (k % 2 == 1) total = total - longint'(term);
      else total = total + longint'(term);
    end
    if (total < 0) total = 0;
    r = u64_t'(total);
    for (k = 0; k < q; k++) r = (r * u64_t'(EINV_Q32)) >> 32;
    return r;
  endfunction

  function automatic longint log_posterior(coef_vec_t b, logic signed [31:0] s_in);
    int unsigned n;
    int unsigned p;
    int unsigned i;
    int unsigned j;
    u64_t        s;
    u64_t        q;
    u64_t        rem;
    longint      sumb2;
    longint      ssr;
    longint      mu;
    longint      r;
    longint      pr;
    longint      a;
    longint      bt;
    longint      c;
    longint      d;
    n = rows_used();
    p = coefs_used();
    s = (s_in > 0) ? u64_t'(s_in) : 1;
    sumb2 = 0;
    ssr = 0;
    for (j = 0; j < p; j++) begin
      pr = longint'($signed(b[j])) * longint'($signed(b[j]));
      sumb2 = clip(sumb2 + (pr >>> FRAC_BITS), 0, LP_MAX_W);
    end
    for (i = 0; i < n; i++) begin
      mu = 0;
      for (j = 0; j < p; j++) begin
        pr = longint'(x_mem[i*MRS_MAX_COEFS+j]) * longint'($signed(b[j]));
        mu = clip(mu + (pr >>> FRAC_BITS), LP_MIN_W, LP_MAX_W);
      end
      r = clip(longint'(y_mem[i]) - mu, W32_MIN_W, W32_MAX_W);
      ssr = clip(ssr + ((r * r) >>> FRAC_BITS), 0, LP_MAX_W);
    end
    a = (longint'(n + 3) * natural_log(s)) >>> 1;
    bt = longint'((u64_t'(sumb2) * u64_t'(HALF_MILLI_Q24)) >> 24);
    c = clip(longint'((u64_t'(3) << (2 * FRAC_BITS - 1)) / s), 0, LP_MAX_W);
    q = u64_t'(ssr) / s;
    rem = u64_t'(ssr) % s;
    if (q > (u64_t'(LP_MAX_W) >> (FRAC_BITS - 1))) begin
      sat_flag = 1'b1;
      d = LP_MAX_W;
    end else begin
      d = longint'((q << (FRAC_BITS - 1)) + ((rem << (FRAC_BITS - 1)) / s));
      d = clip(d, 0, LP_MAX_W);
    end
    return clip(-a - bt - c - d, LP_MIN_W, LP_MAX_W);
  endfunction

  task automatic run_step();
    int unsigned p;
    int unsigned j;
    longint      sp;
    longint      nlp;
    longint      diff;
    longint      dlt;
    bit          acc;
    param_t      e;
    p = coefs_used();
    acc = 1'b0;
    sat_flag = 1'b0;
    sp = clip(longint'(variance) + ((longint'(step_cfg) * longint'(data_value)) >>> FRAC_BITS),
              W32_MIN_W, W32_MAX_W);
    if (sp > 0) begin
      for (j = 0; j < p; j++) begin
        dlt = (longint'(step_cfg) * longint'(noise_mem[j])) >>> FRAC_BITS;
        prop[j] = 32'(clip(longint'($signed(coef[j])) + dlt, W32_MIN_W, W32_MAX_W));
      end
      if (!lp_fresh) begin
        cur_lp = log_posterior(coef, variance);
        lp_fresh = 1'b1;
      end
      nlp = log_posterior(prop, 32'(sp));
      diff = nlp - cur_lp;
      if (diff >= 0) acc = 1'b1;
      else acc = u64_t'(uniform_draw) < (exp_neg(-diff) >> 16);
      if (acc) begin
        for (j = 0; j < p; j++) coef[j] = prop[j];
        variance = 32'(sp);
        cur_lp = nlp;
        accept_count++;
      end
    end
    for (j = 0; j <= p; j++) begin
      e.index = 4'(j);
      e.value = (j < p) ? $signed(coef[j]) : variance;
      e.acc = acc;
      e.sat = sat_flag;
      e.lst = (j == p);
      expected_params.push_back(e);
    end
    step_count++;
  endtask

  task automatic report_mismatch(string what, longint got, longint want);
    $display("%0t mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    fail_count++;
  endtask

  task automatic check_result();
    param_t e;
    result_count++;
    if (expected_params.size() == 0) begin
      report_mismatch("param_index with no step pending", param_index, -1);
    end else begin
      e = expected_params.pop_front();
      if (param_index !== e.index) report_mismatch("param_index", param_index, e.index);
      if (param_value !== e.value) report_mismatch("param_value", param_value, e.value);
      if (accepted !== e.acc) report_mismatch("accepted", accepted, e.acc);
      if (saturated !== e.sat) report_mismatch("saturated", saturated, e.sat);
      if (last !== e.lst) report_mismatch("last", last, e.lst);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      expected_params.delete();
      for (int i = 0; i < MRS_MAX_ROWS * MRS_MAX_COEFS; i++) x_mem[i] = '0;
      for (int i = 0; i < MRS_MAX_ROWS; i++) y_mem[i] = '0;
      for (int i = 0; i < MRS_MAX_COEFS; i++) noise_mem[i] = '0;
      coef = '0;
      prop = '0;
      variance = 32'sd65536;
      cur_lp = 0;
      lp_fresh = 1'b0;
      rows_cfg = ROW_COUNT_RST;
      coefs_cfg = COEF_COUNT_RST;
      step_cfg = STEP_SIZE_RST;
      fail_count = 0;
      request_count = 0;
      step_count = 0;
      accept_count = 0;
      result_count = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_ROW_COUNT: begin
            rows_cfg = pwdata[8:0];
            lp_fresh = 1'b0;
          end
          REG_COEF_COUNT: begin
            coefs_cfg = pwdata[3:0];
            lp_fresh = 1'b0;
          end
          REG_STEP_SIZE: step_cfg = pwdata[30:0];
          default: ;
        endcase
      end
      if (rsp_valid && !rsp_stall) check_result();
      if (req_valid && !req_stall) begin
        request_count++;
        case (func)
          FUNC_LOAD_X: begin
            x_mem[row_index*MRS_MAX_COEFS+col_index] = data_value;
            lp_fresh = 1'b0;
          end
          FUNC_LOAD_Y: begin
            y_mem[row_index] = data_value;
            lp_fresh = 1'b0;
          end
          FUNC_LOAD_NOISE: noise_mem[col_index] = data_value;
          default: run_step();
        endcase
      end
    end
    pending_count = expected_params.size();
  end

endmodule

// ===== test/tb_metropolis_regression_sampler_top.sv =====
// Testbench top for the regression sampler: clock, reset, register setup, requests, verdict.
`timescale 1ns / 100ps
module tb_metropolis_regression_sampler_top;
  import mrs_pkg::*;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [3:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;
  logic               req_valid = 1'b0;
  logic               req_stall;
  logic [1:0]         func = FUNC_LOAD_X;
  logic [7:0]         row_index = '0;
  logic [2:0]         col_index = '0;
  logic signed [31:0] data_value = '0;
  logic [15:0]        uniform_draw = '0;
  logic               rsp_valid;
  logic               rsp_stall = 1'b0;
  logic [3:0]         param_index;
  logic signed [31:0] param_value;
  logic               accepted;
  logic               saturated;
  logic               last;

  int fail_count;
  int pending_count;
  int request_count;
  int step_count;
  int accept_count;
  int result_count;
  int setting_count = 1;
  bit idle_on = 1'b0;
  bit x_loaded[MRS_MAX_ROWS][MRS_MAX_COEFS];
  bit y_loaded[MRS_MAX_ROWS];

  metropolis_regression_sampler_top u_top (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .req_valid(req_valid), .req_stall(req_stall), .func(func), .row_index(row_index),
    .col_index(col_index), .data_value(data_value), .uniform_draw(uniform_draw),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .param_index(param_index),
    .param_value(param_value), .accepted(accepted), .saturated(saturated), .last(last)
  );

  mrs_checker u_check (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .pready(pready), .paddr(paddr), .pwdata(pwdata),
    .req_valid(req_valid), .req_stall(req_stall), .func(func), .row_index(row_index),
    .col_index(col_index), .data_value(data_value), .uniform_draw(uniform_draw),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .param_index(param_index),
    .param_value(param_value), .accepted(accepted), .saturated(saturated), .last(last),
    .fail_count(fail_count), .pending_count(pending_count), .request_count(request_count),
    .step_count(step_count), .accept_count(accept_count), .result_count(result_count)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(negedge clk) begin
    rsp_stall <= idle_on && ($urandom_range(99) < 25);
  end

  initial begin
    #(100_000_000);
    $display("timeout with %0d results pending", pending_count);
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic logic [31:0] near(int span);
    return 32'(int'($urandom_range(2 * span)) - span);
  endfunction

  function automatic logic [31:0] any_or_near(int span);
    return ($urandom_range(9) == 0) ? $urandom : near(span);
  endfunction

  task automatic push_request(logic [1:0] f, logic [7:0] r, logic [2:0] c,
                              logic [31:0] v, logic [15:0] u);
    while (idle_on && $urandom_range(99) < 25) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req_valid <= 1'b1;
    func <= f;
    row_index <= r;
    col_index <= c;
    data_value <= v;
    uniform_draw <= u;
    do @(posedge clk); while (req_stall);
    if (f == FUNC_LOAD_X) x_loaded[r][c] = 1'b1;
    if (f == FUNC_LOAD_Y) y_loaded[r] = 1'b1;
    @(negedge clk);
  endtask

  task automatic drain(int hold);
    req_valid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (hold) @(negedge clk);
  endtask

  task automatic write_register(logic [1:0] idx, logic [31:0] value);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic fill_region(int n, int p);
    int nn;
    int pp;
    nn = (n > MRS_MAX_ROWS) ? MRS_MAX_ROWS : n;
    pp = (p > MRS_MAX_COEFS) ? MRS_MAX_COEFS : p;
    for (int i = 0; i < nn; i++) begin
      if (!y_loaded[i]) begin
        push_request(FUNC_LOAD_Y, 8'(i), 3'($urandom), near(4 * 65536), 16'($urandom));
      end
      for (int j = 0; j < pp; j++) begin
        if (!x_loaded[i][j]) begin
          push_request(FUNC_LOAD_X, 8'(i), 3'(j), near(2 * 65536), 16'($urandom));
        end
      end
    end
  endtask

  initial begin
    int rows_tab[7];
    int coefs_tab[7];
    int steps_tab[7];
    int items_tab[7];
    int nn;
    int roll;
    logic [7:0] r;
    rows_tab = '{4, 0, 8, 3, 24, 12, 2};
    coefs_tab = '{3, 0, 8, 15, 1, 1, 2};
    steps_tab = '{65536, 20000, 442, 2147483647, 3000, 0, 100000};
    items_tab = '{30, 10, 40, 15, 25, 10, 40};
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset register values: one row, one coefficient
    push_request(FUNC_LOAD_X, 0, 0, 32'sd65536, 0);
    push_request(FUNC_LOAD_Y, 0, 0, 32'h7FFF_FFFF, 0);
    push_request(FUNC_LOAD_NOISE, 0, 0, 32'h8000_0000, 0);
    push_request(FUNC_LOAD_NOISE, 0, 7, 32'h7FFF_FFFF, 16'hFFFF);
    push_request(FUNC_STEP, 0, 0, 0, 0);
    push_request(FUNC_STEP, 8'hFF, 7, 32'h7FFF_FFFF, 16'hFFFF);
    push_request(FUNC_STEP, 0, 0, 32'h8000_0000, 0);
    push_request(FUNC_LOAD_Y, 0, 0, 32'sd131072, 0);
    push_request(FUNC_LOAD_NOISE, 0, 0, 32'sd65536, 0);
    push_request(FUNC_STEP, 0, 0, 32'sd65536, 16'h8000);
    push_request(FUNC_LOAD_X, 8'hFF, 7, 32'hFFFF_FFFF, 16'hFFFF);
    push_request(FUNC_STEP, 0, 0, 32'hFFFF_FFFF, 16'hFFFF);
    push_request(FUNC_LOAD_Y, 8'hFF, 0, 32'h8000_0000, 0);
    push_request(FUNC_STEP, 0, 0, 32'sd1, 0);
    push_request(FUNC_STEP, 0, 0, -32'sd30000, 16'h0001);

    for (int ph = 0; ph < 7; ph++) begin
      drain(40);
      idle_on = 1'b0;
      write_register(REG_ROW_COUNT, rows_tab[ph]);
      write_register(REG_COEF_COUNT, coefs_tab[ph]);
      write_register(REG_STEP_SIZE, steps_tab[ph]);
      setting_count++;
      fill_region(rows_tab[ph], coefs_tab[ph]);
      idle_on = (ph != 2);
      nn = (rows_tab[ph] > MRS_MAX_ROWS) ? MRS_MAX_ROWS : rows_tab[ph];
      for (int k = 0; k < items_tab[ph]; k++) begin
        roll = $urandom_range(99);
        r = (nn == 0 || $urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(nn - 1));
        if (roll < 45) begin
          push_request(FUNC_STEP, 8'($urandom), 3'($urandom), any_or_near(2 * 65536),
                       16'($urandom));
        end else if (roll < 65) begin
          push_request(FUNC_LOAD_NOISE, 8'($urandom), 3'($urandom), any_or_near(65536),
                       16'($urandom));
        end else if (roll < 85) begin
          push_request(FUNC_LOAD_X, r, 3'($urandom), any_or_near(2 * 65536), 16'($urandom));
        end else begin
          push_request(FUNC_LOAD_Y, r, 3'($urandom), any_or_near(4 * 65536), 16'($urandom));
        end
      end
    end

    drain(60);
    $display("Covered %0d requests and %0d steps (%0d accepted), %0d results compared,",
             request_count, step_count, accept_count, result_count);
    $display("over %0d register settings including zero and over-range counts.",
             setting_count);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
